>>> rtl/apem_pkg.sv
// Shared types, constants and sample helpers for the audio peak/energy meter.
`default_nettype none
package apem_pkg;

    localparam int unsigned MAX_CHANNELS = 16;
    localparam int unsigned CH_W         = 4;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned PEAK_W       = 32;
    localparam int unsigned ENERGY_W     = 64;
    localparam int unsigned FRAME_W      = 40;
    localparam int unsigned ENTRY_W      = PEAK_W + ENERGY_W;

    localparam logic [1:0] FUNC_ACC    = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [2:0] BPS_16 = 3'd2;
    localparam logic [2:0] BPS_24 = 3'd3;
    localparam logic [2:0] BPS_32 = 3'd4;

    localparam logic       REG_BPS      = 1'b0;
    localparam logic       REG_CHANNELS = 1'b1;

    localparam logic [2:0]       BPS_RESET      = BPS_24;
    localparam logic [CNT_W-1:0] CHANNELS_RESET = CNT_W'(6);

    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

    // per-channel store entry
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [PEAK_W-1:0]   peak;
    } entry_t;

    function automatic logic [31:0] left_justify(input logic [31:0] w, input logic [2:0] bps);
        logic [31:0] v;
        begin
            unique case (bps)
                BPS_16:  v = {w[15:0], 16'h0000};
                BPS_24:  v = {w[23:0], 8'h00};
                BPS_32:  v = w;
                default: v = 32'h0000_0000;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/apem_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module apem_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/apem_acc.sv
// Sample datapath: left-justify, magnitude, squared top half, entry update.
`default_nettype none
module apem_acc
    import apem_pkg::*;
(
    input  wire         aclk,
    input  wire         load,
    input  wire  [31:0] sample_word,
    input  wire  [2:0]  sample_bytes,
    input  wire         square_en,
    input  entry_t      old_entry,
    output entry_t      new_entry
);

    logic [31:0] v_reg;
    logic [31:0] sq_reg;
    logic [31:0] sq_next;
    logic [15:0] top;
    logic [15:0] m16;
    logic [31:0] mag;
    logic [ENERGY_W:0] sum;

    assign top     = v_reg[31:16];
    assign m16     = top[15] ? (~top + 16'd1) : top;
    assign sq_next = 32'(m16) * 32'(m16);

    always_ff @(posedge aclk) begin
        if (load) begin
            v_reg <= left_justify(sample_word, sample_bytes);
        end
        if (square_en) begin
            sq_reg <= sq_next;
        end
    end

    assign mag = v_reg[31] ? (~v_reg + 32'd1) : v_reg;
    assign sum = {1'b0, old_entry.energy} + (ENERGY_W+1)'(sq_reg);

    always_comb begin
        new_entry.peak   = (mag > old_entry.peak) ? mag : old_entry.peak;
        new_entry.energy = sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
    end

endmodule
`default_nettype wire

>>> rtl/audio_peak_energy_meter_unit.sv
// Top level of the multichannel audio peak and energy meter.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata {channel, sample_word}, s_tuser func
// m_       out  m_tvalid/m_tready  m_tdata report fields, m_tlast last channel
// cfg_     in   cfg_we             cfg_index, cfg_data
//
// Accumulate: accept, store read, store write-back per sample. Clear, ignored
// samples and unused codes: accept only. Report: store read, load, output per
// channel plus any m_tready stall; the single read port of the channel store
// sets the pace. Reset and clear drop per-entry valid bits at once; no sweep.
// Input is held off while an item is in flight.
`default_nettype none
module audio_peak_energy_meter_unit
    import apem_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [39:0]  s_tdata,   // sample_word[31:0], channel[35:32], zero pad
    input  wire  [1:0]   s_tuser,   // func[1:0]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [143:0] m_tdata,   // out_channel[3:0], peak_magnitude[35:4],
                                    // energy_sum[99:36], frames_counted[139:100],
                                    // no_samples[140], zero pad
    output logic         m_tlast,
    input  wire          cfg_we,
    input  wire          cfg_index,
    input  wire  [4:0]   cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RD      = 6'b000010,
        S_WR      = 6'b000100,
        S_REP_RD  = 6'b001000,
        S_REP_LD  = 6'b010000,
        S_REP_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]             bps_reg;
    logic [CNT_W-1:0]       chans_reg;
    logic [CNT_W-1:0]       active_n;
    logic [CH_W-1:0]        addr_reg, addr_next;
    logic [MAX_CHANNELS-1:0] valid_reg, valid_next;
    logic [FRAME_W-1:0]     frame_reg, frame_next;

    logic [3:0]             out_ch_reg;
    logic [PEAK_W-1:0]      out_peak_reg;
    logic [ENERGY_W-1:0]    out_energy_reg;
    logic [FRAME_W-1:0]     out_frames_reg;
    logic                   out_none_reg;
    logic                   out_last_reg;

    logic        accept;
    logic [1:0]  func;
    logic [CH_W-1:0] in_ch;
    logic        ch_active;
    logic        is_last_ch;
    logic        ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t      old_entry, new_entry;
    logic        out_done;

    assign func     = s_tuser;
    assign in_ch    = s_tdata[35:32];
    assign active_n = (chans_reg > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : chans_reg;
    assign ch_active = CNT_W'(in_ch) < active_n;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_last_ch = (CNT_W'(addr_reg) == active_n - CNT_W'(1));
    assign out_done = m_tvalid && m_tready;
    assign ram_we   = (state_reg == S_WR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg   <= BPS_RESET;
            chans_reg <= CHANNELS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BPS:      bps_reg   <= cfg_data[2:0];
                REG_CHANNELS: chans_reg <= cfg_data;
                default:      bps_reg   <= bps_reg;
            endcase
        end
    end

    apem_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_CHANNELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (new_entry),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign old_entry = valid_reg[addr_reg] ? entry_t'(ram_rdata) : entry_t'('0);

    apem_acc u_acc (
        .aclk         (aclk),
        .load         (accept),
        .sample_word  (s_tdata[31:0]),
        .sample_bytes (bps_reg),
        .square_en    (state_reg == S_RD),
        .old_entry    (old_entry),
        .new_entry    (new_entry)
    );

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        valid_next = valid_reg;
        frame_next = frame_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (func == FUNC_ACC) begin
                        if (ch_active) begin
                            addr_next  = in_ch;
                            state_next = S_RD;
                            if (CNT_W'(in_ch) == active_n - CNT_W'(1) && frame_reg != FRAME_MAX) begin
                                frame_next = frame_reg + FRAME_W'(1);
                            end
                        end
                    end else if (func == FUNC_REPORT) begin
                        if (active_n != '0) begin
                            addr_next  = '0;
                            state_next = S_REP_RD;
                        end
                    end else if (func == FUNC_CLEAR) begin
                        valid_next = '0;
                        frame_next = '0;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD:     state_next = S_WR;
            S_WR: begin
                valid_next[addr_reg] = 1'b1;
                state_next = S_IDLE;
            end
            S_REP_RD: state_next = S_REP_LD;
            S_REP_LD: state_next = S_REP_OUT;
            S_REP_OUT: begin
                if (out_done) begin
                    if (out_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        addr_next  = addr_reg + CH_W'(1);
                        state_next = S_REP_RD;
                    end
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            frame_reg <= '0;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            frame_reg <= frame_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_REP_LD) begin
            out_ch_reg     <= addr_reg;
            out_peak_reg   <= old_entry.peak;
            out_energy_reg <= old_entry.energy;
            out_frames_reg <= frame_reg;
            out_none_reg   <= (frame_reg == '0);
            out_last_reg   <= is_last_ch;
        end
    end

    assign m_tvalid = (state_reg == S_REP_OUT);
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_none_reg, out_frames_reg, out_energy_reg,
                       out_peak_reg, out_ch_reg};

    // no new transfer taken while a report item is pending
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during report");

    // store write-back only follows a read of the same entry
    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(state_reg == S_RD) && $stable(addr_reg))
        else $error("write-back without preceding read");

    // clear empties the frame counter and valid bits
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_CLEAR) |=> (frame_reg == '0) && (valid_reg == '0))
        else $error("clear did not take effect");

    // frame counter changes only on an accepted sample or clear
    a_frame_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && (func == FUNC_ACC || func == FUNC_CLEAR)) |=> $stable(frame_reg))
        else $error("frame counter changed without a sample");

endmodule
`default_nettype wire

>>> tb/tb_audio_peak_energy_meter_unit.sv
// Self-checking testbench for the audio peak/energy meter: directed table, then random frames.
`timescale 1ns / 1ps
module tb_audio_peak_energy_meter_unit;
    import apem_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 125;

    typedef struct packed {
        logic [CH_W-1:0]     chan;
        logic [PEAK_W-1:0]   peak;
        logic [ENERGY_W-1:0] energy;
        logic [FRAME_W-1:0]  frames;
        logic                idle;
        logic                tail;
    } meter_report_t;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        logic [1:0]          func;
        logic [31:0]         word;
        logic [CH_W-1:0]     chan;
        logic                reg_sel;
        logic [CNT_W-1:0]    reg_val;
        logic                typed;
        logic [PEAK_W-1:0]   peak;
        logic [ENERGY_W-1:0] energy;
        logic [FRAME_W-1:0]  frames;
    } plan_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we;
    logic         cfg_index;
    logic [4:0]   cfg_data;

    // predictor state
    logic [PEAK_W-1:0]   peak_mem   [MAX_CHANNELS];
    logic [ENERGY_W-1:0] energy_mem [MAX_CHANNELS];
    logic [FRAME_W-1:0]  frame_cnt;
    logic [2:0]          width_cfg;
    logic [CNT_W-1:0]    chan_cfg;

    meter_report_t reports_due[$];
    plan_row_t     plan[$];

    int unsigned errors;
    int unsigned inputs_sent;
    int unsigned reports_seen;
    int unsigned reg_writes;
    bit          calm;

    audio_peak_energy_meter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned active_count();
        int unsigned n;
        n = chan_cfg;
        if (n > MAX_CHANNELS) n = MAX_CHANNELS;
        return n;
    endfunction

    function automatic logic [31:0] align_sample(logic [31:0] w);
        if (width_cfg == BPS_16) return w << 16;
        if (width_cfg == BPS_24) return w << 8;
        if (width_cfg == BPS_32) return w;
        return 32'h0;
    endfunction

    function automatic void clear_meter();
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            peak_mem[i]   = '0;
            energy_mem[i] = '0;
        end
        frame_cnt = '0;
    endfunction

    // returns the number of report transfers queued
    function automatic int unsigned meter_apply(logic [1:0] f, logic [31:0] w,
                                                logic [CH_W-1:0] c);
        int unsigned   n;
        int unsigned   made;
        logic [31:0]   v;
        logic [31:0]   mag;
        logic [15:0]   top;
        logic [16:0]   m16;
        logic [63:0]   sq;
        logic [64:0]   sum;
        meter_report_t r;
        n = active_count();
        made = 0;
        case (f)
            FUNC_ACC: begin
                if (c < n) begin
                    v   = align_sample(w);
                    mag = v[31] ? (~v + 32'd1) : v;
                    top = v[31:16];
                    m16 = top[15] ? (17'h10000 - {1'b0, top}) : {1'b0, top};
                    sq  = 64'(m16) * 64'(m16);
                    if (mag > peak_mem[c]) peak_mem[c] = mag;
                    sum = {1'b0, energy_mem[c]} + {1'b0, sq};
                    energy_mem[c] = sum[64] ? {ENERGY_W{1'b1}} : sum[63:0];
                    if (c == n - 1 && frame_cnt != FRAME_MAX) frame_cnt = frame_cnt + 1'b1;
                end
            end
            FUNC_REPORT: begin
                for (int unsigned i = 0; i < n; i++) begin
                    r.chan   = CH_W'(i);
                    r.peak   = peak_mem[i];
                    r.energy = energy_mem[i];
                    r.frames = frame_cnt;
                    r.idle   = (frame_cnt == '0);
                    r.tail   = (i == n - 1);
                    reports_due = {reports_due, r};
                end
                made = n;
            end
            FUNC_CLEAR: clear_meter();
            default: ;
        endcase
        return made;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                if (width_cfg == BPS_16) return {16'($urandom), 16'h8000};
                if (width_cfg == BPS_24) return {8'($urandom), 24'h800000};
                return 32'h8000_0000;
            end
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic plan_row_t cfg_row(logic sel, logic [CNT_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.kind = STEP_CFG;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    function automatic plan_row_t item_row(logic [1:0] f, logic [31:0] w, logic [CH_W-1:0] c);
        plan_row_t row;
        row = '0;
        row.kind = STEP_ITEM;
        row.func = f;
        row.word = w;
        row.chan = c;
        return row;
    endfunction

    // report whose entry for channel c is typed in by hand
    function automatic plan_row_t typed_report(logic [CH_W-1:0] c, logic [31:0] pk,
                                               logic [63:0] en, logic [39:0] fr);
        plan_row_t row;
        row = item_row(FUNC_REPORT, 32'h0, c);
        row.typed  = 1'b1;
        row.peak   = pk;
        row.energy = en;
        row.frames = fr;
        return row;
    endfunction

    task automatic push_item(input logic [1:0] f, input logic [31:0] w,
                             input logic [CH_W-1:0] c, output int unsigned made);
        int unsigned gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'h0, c, w};
        s_tuser  = f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        made = meter_apply(f, w, c);
        inputs_sent++;
    endtask

    // drain the result stream and let accumulates in flight retire
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [CNT_W-1:0] val);
        settle();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        @(posedge aclk);
        if (sel == REG_BPS) width_cfg = val[2:0];
        else chan_cfg = val;
        reg_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0d ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        meter_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen++;
            if (reports_due.size() == 0) begin
                $display("%0d ns: unexpected report transfer, channel %0d", $time,
                         m_tdata[3:0]);
                errors++;
            end else begin
                want = reports_due.pop_front();
                check_field("out_channel", 64'(want.chan), 64'(m_tdata[3:0]));
                check_field("peak_magnitude", 64'(want.peak), 64'(m_tdata[35:4]));
                check_field("energy_sum", want.energy, m_tdata[99:36]);
                check_field("frames_counted", 64'(want.frames), 64'(m_tdata[139:100]));
                check_field("no_samples", 64'(want.idle), 64'(m_tdata[140]));
                check_field("tlast", 64'(want.tail), 64'(m_tlast));
            end
        end
    end

    // result-side backpressure
    initial begin : sink_stall
        int unsigned hold;
        hold = 0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("%0d ns: timeout, %0d reports still pending", $time, reports_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int unsigned made;
        int unsigned idx;
        int unsigned r;
        int unsigned n;
        int unsigned next_ch;
        int unsigned rand_items;
        meter_report_t fix;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_ACC;
        cfg_we    = 1'b0;
        cfg_index = REG_BPS;
        cfg_data  = '0;
        aresetn   = 1'b0;
        errors = 0;
        inputs_sent = 0;
        reports_seen = 0;
        reg_writes = 0;
        calm = 1'b0;
        width_cfg = BPS_RESET;
        chan_cfg  = CHANNELS_RESET;
        clear_meter();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        plan = {plan, typed_report(4'd0, 32'h0, 64'h0, 40'h0)};
        plan = {plan, cfg_row(REG_BPS, 5'(BPS_32))};
        plan = {plan, item_row(FUNC_ACC, 32'h8000_0000, 4'd0)};
        plan = {plan, item_row(FUNC_ACC, 32'h7FFF_FFFF, 4'd0)};
        plan = {plan, typed_report(4'd0, 32'h8000_0000, 64'h7FFF_0001, 40'h0)};
        plan = {plan, item_row(FUNC_ACC, 32'h0000_0001, 4'd1)};
        plan = {plan, item_row(FUNC_ACC, 32'hFFFF_FFFF, 4'd2)};
        plan = {plan, item_row(FUNC_ACC, 32'h1234_5678, 4'd3)};
        plan = {plan, item_row(FUNC_ACC, 32'hFFFF_0000, 4'd4)};
        plan = {plan, item_row(FUNC_ACC, 32'h0001_0000, 4'd5)};
        plan = {plan, item_row(FUNC_ACC, 32'hDEAD_BEEF, 4'd6)};
        plan = {plan, item_row(FUNC_ACC, 32'hCAFE_F00D, 4'd15)};
        plan = {plan, item_row(FUNC_UNUSED, 32'hA5A5_A5A5, 4'd0)};
        plan = {plan, item_row(FUNC_REPORT, 32'h0, 4'd0)};
        plan = {plan, item_row(FUNC_CLEAR, 32'h0, 4'd0)};
        plan = {plan, typed_report(4'd0, 32'h0, 64'h0, 40'h0)};
        plan = {plan, cfg_row(REG_BPS, 5'(BPS_16))};
        plan = {plan, item_row(FUNC_ACC, 32'hFFFF_8000, 4'd1)};
        plan = {plan, item_row(FUNC_ACC, 32'h0000_7FFF, 4'd2)};
        plan = {plan, cfg_row(REG_BPS, 5'(BPS_24))};
        plan = {plan, item_row(FUNC_ACC, 32'hAB80_0000, 4'd3)};
        plan = {plan, cfg_row(REG_BPS, 5'd7)};
        plan = {plan, item_row(FUNC_ACC, 32'hFFFF_FFFF, 4'd5)};
        plan = {plan, cfg_row(REG_CHANNELS, 5'd1)};
        plan = {plan, item_row(FUNC_ACC, 32'h0000_0000, 4'd0)};
        plan = {plan, cfg_row(REG_CHANNELS, 5'd0)};
        plan = {plan, item_row(FUNC_ACC, 32'h7FFF_FFFF, 4'd0)};
        plan = {plan, item_row(FUNC_REPORT, 32'h0, 4'd0)};
        plan = {plan, cfg_row(REG_BPS, 5'(BPS_32))};
        plan = {plan, cfg_row(REG_CHANNELS, 5'd31)};
        plan = {plan, item_row(FUNC_ACC, 32'h8000_0000, 4'd15)};
        plan = {plan, item_row(FUNC_REPORT, 32'h0, 4'd0)};
        plan = {plan, cfg_row(REG_CHANNELS, 5'd16)};

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_CFG) begin
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end else begin
                push_item(plan[i].func, plan[i].word, plan[i].chan, made);
                if (plan[i].typed) begin
                    idx = reports_due.size() - made + plan[i].chan;
                    fix = reports_due[idx];
                    fix.peak   = plan[i].peak;
                    fix.energy = plan[i].energy;
                    fix.frames = plan[i].frames;
                    fix.idle   = (plan[i].frames == '0);
                    reports_due[idx] = fix;
                end
            end
        end

        // random phases: one setting each, mostly in-order frames
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) write_reg(REG_BPS, 5'($urandom_range(2, 4)));
            else write_reg(REG_BPS, 5'($urandom_range(0, 7)));
            r = $urandom_range(0, 99);
            if (r < 70) write_reg(REG_CHANNELS, 5'($urandom_range(1, 8)));
            else if (r < 88) write_reg(REG_CHANNELS, 5'($urandom_range(9, 16)));
            else write_reg(REG_CHANNELS, 5'($urandom_range(0, 31)));
            calm = ($urandom_range(0, 3) == 0);
            next_ch = 0;
            repeat ($urandom_range(15, 35)) begin
                r = $urandom_range(0, 99);
                n = active_count();
                if (r < 84 && n > 0) begin
                    push_item(FUNC_ACC, pick_word(), CH_W'(next_ch), made);
                    next_ch = (next_ch + 1 == n) ? 0 : next_ch + 1;
                end else if (r < 90) begin
                    push_item(FUNC_ACC, pick_word(), CH_W'($urandom_range(0, 15)), made);
                end else if (r < 96) begin
                    push_item(FUNC_REPORT, $urandom, CH_W'($urandom_range(0, 15)), made);
                end else if (r < 98) begin
                    push_item(FUNC_CLEAR, $urandom, CH_W'($urandom_range(0, 15)), made);
                    next_ch = 0;
                end else begin
                    push_item(FUNC_UNUSED, $urandom, CH_W'($urandom_range(0, 15)), made);
                end
                rand_items++;
            end
            push_item(FUNC_REPORT, $urandom, CH_W'($urandom_range(0, 15)), made);
            calm = 1'b0;
        end

        settle();
        repeat (20) @(posedge aclk);
        $display("Run: %0d input transfers, %0d register writes, %0d report transfers checked",
                 inputs_sent, reg_writes, reports_seen);
        $display("Widths 16/24/32 and unsupported, 0..31 channels, extremes, clear, unused code");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
